@@ src/irtc_pkg.sv @@
// ----------------------------------------------------------------------------
// Interrupt route package
// Shared types and constants for the interrupt route table and counter.
// ----------------------------------------------------------------------------
package irtc_pkg;

  localparam int PIN_ENTRIES_DEF = 24;
  localparam int MSI_DEPTH_DEF = 256;
  localparam logic [31:0] MSI_ADDR_BASE = 32'hFEE0_0000;

  localparam logic [2:0] REQ_PROGRAM = 3'd0;
  localparam logic [2:0] REQ_MASK    = 3'd1;
  localparam logic [2:0] REQ_UNMASK  = 3'd2;
  localparam logic [2:0] REQ_ADD_MSI = 3'd3;
  localparam logic [2:0] REQ_EVENT   = 3'd4;
  localparam logic [2:0] REQ_CLEAR   = 3'd5;

  localparam logic [1:0] CFG_IOAPIC_PRESENT = 2'd0;
  localparam logic [1:0] CFG_PIN_COUNT      = 2'd1;
  localparam logic [1:0] CFG_MSI_ENABLE     = 2'd2;

  localparam logic [1:0] SRC_PIN  = 2'd0;
  localparam logic [1:0] SRC_MSI  = 2'd1;
  localparam logic [1:0] SRC_NONE = 2'd2;

  // One queued request.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  apic_number;
    logic [7:0]  pin;
    logic [7:0]  vector;
    logic [2:0]  dlv_mode;
    logic        dst_logical;
    logic        polarity;
    logic        trig_level;
    logic [7:0]  destination;
    logic        cap_found;
    logic [63:0] tick;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIN_SCAN,
    ST_MSI_READ,
    ST_MSI_CHECK,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

@@ src/irtc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module irtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/irtc_front.sv @@
// ----------------------------------------------------------------------------
// Request front end
// Captures commands into a two-entry queue for the execution back end.
// ----------------------------------------------------------------------------
module irtc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  irtc_pkg::req_t  req_in,
  output logic            busy,
  output logic            q_valid,
  output irtc_pkg::req_t  q_head,
  input  logic            q_pop
);
  import irtc_pkg::*;

  req_t       slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign busy    = (fill == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_head  = slots[rd_ptr];

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && q_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ src/irtc_back.sv @@
// ----------------------------------------------------------------------------
// Request back end
// Executes queued requests against the pin table, MSI list and counters.
// ----------------------------------------------------------------------------
module irtc_back #(
  parameter int PIN_ENTRIES = irtc_pkg::PIN_ENTRIES_DEF,
  parameter int MSI_DEPTH = irtc_pkg::MSI_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [1:0]                     cfg_index,
  input  logic [4:0]                     cfg_data,
  input  logic                           q_valid,
  input  irtc_pkg::req_t                 q_head,
  output logic                           q_pop,
  output logic                           done,
  output logic                           ok,
  output logic [1:0]                     source,
  output logic [4:0]                     hit_pin,
  output logic [31:0]                    hit_pin_count,
  output logic [63:0]                    redirect_word,
  output logic [31:0]                    msg_addr,
  output logic [15:0]                    msg_data,
  output logic [31:0]                    routed_total,
  output logic [31:0]                    pin_event_total,
  output logic [31:0]                    msi_event_total,
  output logic [8:0]                     msi_fill,
  output logic [63:0]                    last_event_tick
);
  import irtc_pkg::*;

  localparam int PW = (PIN_ENTRIES > 1) ? $clog2(PIN_ENTRIES) : 1;
  localparam int PCW = $clog2(PIN_ENTRIES + 1);
  localparam int MW = (MSI_DEPTH > 1) ? $clog2(MSI_DEPTH) : 1;
  localparam int UW = $clog2(MSI_DEPTH + 1);

  // Configuration registers.
  logic       ioapic_present;
  logic [4:0] pin_count;
  logic       msi_enable;

  // Pin table held in flip-flops; each scan step reads one entry.
  logic [7:0]  pin_vector [PIN_ENTRIES];
  logic        pin_masked [PIN_ENTRIES];
  logic [31:0] pin_hits   [PIN_ENTRIES];

  logic [UW-1:0] msi_used;
  logic [31:0]   routed_count;
  logic [31:0]   pin_event_count;
  logic [31:0]   msi_event_count;
  logic [63:0]   last_tick;

  state_t state, state_next;
  req_t   cur;
  logic [PCW-1:0] idx;
  logic [UW-1:0]  midx;
  logic [PCW-1:0] lim;
  logic           pin_ok;
  logic           msi_ok;
  logic [7:0]     ram_rdata;
  logic [PW-1:0]  pidx;
  logic [PW-1:0]  cpin;

  assign cpin = cur.pin[PW-1:0];
  assign pidx = idx[PW-1:0];

  // Effective pin limit.
  always_comb begin
    if (!ioapic_present) begin
      lim = '0;
    end else if (32'(pin_count) < PIN_ENTRIES) begin
      lim = PCW'(pin_count);
    end else begin
      lim = PCW'(PIN_ENTRIES);
    end
  end

  assign pin_ok = ioapic_present && (cur.apic_number == 3'd0) &&
                  ({1'b0, cur.pin} < 9'(lim));
  assign msi_ok = msi_enable && (32'(msi_used) < MSI_DEPTH) && cur.cap_found;

  irtc_ram #(.WIDTH(8), .DEPTH(MSI_DEPTH)) u_msi_ram (
    .clk   (clk),
    .we    (state == ST_DONE && cur.req_type == REQ_ADD_MSI && msi_ok),
    .waddr (msi_used[MW-1:0]),
    .wdata (cur.vector),
    .raddr (midx[MW-1:0]),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_head.req_type)
            REQ_EVENT: state_next = ST_PIN_SCAN;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_PIN_SCAN: begin
        if (idx >= lim) begin
          state_next = (msi_used != '0) ? ST_MSI_READ : ST_DONE;
        end else if (pin_vector[pidx] == cur.vector && !pin_masked[pidx]) begin
          state_next = ST_DONE;
        end
      end
      ST_MSI_READ:  state_next = ST_MSI_CHECK;
      ST_MSI_CHECK: begin
        if (ram_rdata == cur.vector || midx + UW'(1) >= msi_used) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MSI_READ;
        end
      end
      ST_CLEAR: state_next = ST_IDLE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign q_pop = (state == ST_IDLE) && q_valid;

  // Datapath and outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      ioapic_present  <= 1'b1;
      pin_count       <= 5'd24;
      msi_enable      <= 1'b1;
      msi_used        <= '0;
      routed_count    <= '0;
      pin_event_count <= '0;
      msi_event_count <= '0;
      last_tick       <= '0;
      done            <= 1'b0;
      for (int i = 0; i < PIN_ENTRIES; i++) begin
        pin_vector[i] <= '0;
        pin_masked[i] <= 1'b1;
        pin_hits[i]   <= '0;
      end
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IOAPIC_PRESENT: ioapic_present <= cfg_data[0];
          CFG_PIN_COUNT:      pin_count      <= cfg_data;
          CFG_MSI_ENABLE:     msi_enable     <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur  <= q_head;
            idx  <= '0;
            midx <= '0;
            ok            <= 1'b0;
            source        <= SRC_NONE;
            hit_pin       <= '0;
            hit_pin_count <= '0;
            redirect_word <= '0;
            msg_addr      <= '0;
            msg_data      <= '0;
          end
        end
        ST_PIN_SCAN: begin
          if (idx < lim) begin
            if (pin_vector[pidx] == cur.vector && !pin_masked[pidx]) begin
              pin_hits[pidx]  <= pin_hits[pidx] + 32'd1;
              pin_event_count <= pin_event_count + 32'd1;
              source          <= SRC_PIN;
              hit_pin         <= 5'(idx);
              hit_pin_count   <= pin_hits[pidx] + 32'd1;
            end
            idx <= idx + PCW'(1);
          end
        end
        ST_MSI_CHECK: begin
          if (ram_rdata == cur.vector) begin
            msi_event_count <= msi_event_count + 32'd1;
            source          <= SRC_MSI;
          end
          midx <= midx + UW'(1);
        end
        ST_DONE: begin
          case (cur.req_type)
            REQ_PROGRAM: begin
              if (pin_ok) begin
                pin_vector[cpin] <= cur.vector;
                pin_masked[cpin] <= 1'b0;
                routed_count     <= routed_count + 32'd1;
                redirect_word    <= {cur.destination, 40'd0, cur.trig_level, 1'b0,
                                     cur.polarity, 1'b0, cur.dst_logical,
                                     cur.dlv_mode, cur.vector};
                ok <= 1'b1;
              end
            end
            REQ_MASK, REQ_UNMASK: begin
              if (pin_ok) begin
                pin_masked[cpin] <= (cur.req_type == REQ_MASK);
                ok <= 1'b1;
              end
            end
            REQ_ADD_MSI: begin
              if (msi_ok) begin
                msi_used     <= msi_used + UW'(1);
                routed_count <= routed_count + 32'd1;
                msg_addr     <= MSI_ADDR_BASE | {12'd0, cur.destination, 12'd0};
                msg_data     <= {8'd0, cur.vector};
                ok <= 1'b1;
              end
            end
            REQ_EVENT: begin
              ok        <= 1'b1;
              last_tick <= cur.tick;
            end
            REQ_CLEAR: begin
              ok              <= 1'b1;
              routed_count    <= '0;
              pin_event_count <= '0;
              msi_event_count <= '0;
              if (ioapic_present) begin
                for (int i = 0; i < PIN_ENTRIES; i++) begin
                  pin_hits[i] <= '0;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Status totals follow the registered state.
  assign routed_total     = routed_count;
  assign pin_event_total  = pin_event_count;
  assign msi_event_total  = msi_event_count;
  assign msi_fill         = 9'(msi_used);
  assign last_event_tick  = last_tick;

endmodule

@@ src/interrupt_route_table_and_counter_core.sv @@
// ----------------------------------------------------------------------------
// Interrupt route table and counter core
// Pin redirection table, MSI vector list and interrupt statistics.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. A
// two-entry queue holds commands; busy rises only when it is full.
// The back end executes one command at a time. Program, mask, unmask, add
// MSI, clear and unknown commands go from the queue head in ST_IDLE to
// ST_DONE, and the done strobe is registered from ST_DONE; the back end
// takes the next queued command only after it is back in ST_IDLE.
// An interrupt event scans the pins one per cycle (up to the pin limit) and,
// if no unmasked pin matches the vector, then the MSI list, each entry
// through ST_MSI_READ and ST_MSI_CHECK on the list RAM's registered read
// port; either scan stops at the first match.
// Each result is shown for one cycle with done high; the receiver cannot
// stall. Configuration writes use cfg_valid/cfg_ready and are always taken.
// Reset restores defaults, masks all pins and clears all counters; the MSI
// list needs no clearing since only appended entries are read.
// ----------------------------------------------------------------------------
module interrupt_route_table_and_counter_core #(
  parameter int PIN_ENTRIES = irtc_pkg::PIN_ENTRIES_DEF,
  parameter int MSI_DEPTH = irtc_pkg::MSI_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [2:0]  apic_number,
  input  logic [7:0]  pin,
  input  logic [7:0]  vector,
  input  logic [2:0]  dlv_mode,
  input  logic        dst_logical,
  input  logic        polarity,
  input  logic        trig_level,
  input  logic [7:0]  destination,
  input  logic        cap_found,
  input  logic [63:0] tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic        ok,
  output logic [1:0]  source,
  output logic [4:0]  hit_pin,
  output logic [31:0] hit_pin_count,
  output logic [63:0] redirect_word,
  output logic [31:0] msg_addr,
  output logic [15:0] msg_data,
  output logic [31:0] routed_total,
  output logic [31:0] pin_event_total,
  output logic [31:0] msi_event_total,
  output logic [8:0]  msi_fill,
  output logic [63:0] last_event_tick
);
  import irtc_pkg::*;

  req_t req_in;
  req_t q_head;
  logic q_valid;
  logic q_pop;

  assign cfg_ready = 1'b1;
  assign req_in = '{req_type, apic_number, pin, vector, dlv_mode, dst_logical,
                    polarity, trig_level, destination, cap_found, tick};

  irtc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_in  (req_in),
    .busy    (busy),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  irtc_back #(.PIN_ENTRIES(PIN_ENTRIES), .MSI_DEPTH(MSI_DEPTH)) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .done             (done),
    .ok               (ok),
    .source           (source),
    .hit_pin          (hit_pin),
    .hit_pin_count    (hit_pin_count),
    .redirect_word    (redirect_word),
    .msg_addr         (msg_addr),
    .msg_data         (msg_data),
    .routed_total     (routed_total),
    .pin_event_total  (pin_event_total),
    .msi_event_total  (msi_event_total),
    .msi_fill         (msi_fill),
    .last_event_tick  (last_event_tick)
  );

endmodule
